FILE: rtl/arsg_pkg.sv
// ----------------------------------------------------------------------------
// arsg_pkg
// Shared widths, codes and the operation record of the allreduce schedule
// generator.
// ----------------------------------------------------------------------------
package arsg_pkg;

  localparam int MAX_RANKS = 1024;

  localparam int RANK_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int STEP_W  = 11;
  localparam int SLOT_W  = 11;
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int NUM_OPS = 3;

  localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(MAX_RANKS);
  localparam logic [SLOT_W-1:0] SLOT_WHOLE = SLOT_W'(MAX_RANKS);

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAST_END = 2'd1;
  localparam logic [1:0] ST_BAD_CFG  = 2'd2;

  // operation kinds
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_RED3 = 2'd2;
  localparam logic [1:0] OP_RED2 = 2'd3;

  // buffer codes
  localparam logic [1:0] BUF_TX   = 2'd0;
  localparam logic [1:0] BUF_RX   = 2'd1;
  localparam logic [1:0] BUF_TEMP = 2'd2;
  localparam logic [1:0] BUF_NONE = 2'd3;

  // algorithm modes
  localparam logic [MODE_W-1:0] MODE_RING  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RDBL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BINOM = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MY_RANK    = 2'd0;
  localparam logic [1:0] REG_GROUP_SIZE = 2'd1;
  localparam logic [1:0] REG_ALG_MODE   = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [STEP_W-1:0] step_count;
    logic [1:0]        op_kind;
    logic [RANK_W-1:0] peer_rank;
    logic [1:0]        first_buffer;
    logic [SLOT_W-1:0] first_slot;
    logic [1:0]        second_buffer;
    logic [SLOT_W-1:0] second_slot;
    logic [1:0]        dest_buffer;
    logic [SLOT_W-1:0] dest_slot;
    logic              last_op;
  } op_t;

endpackage

FILE: rtl/allreduce_schedule_generator.sv
// ----------------------------------------------------------------------------
// allreduce_schedule_generator
// Generates the send, receive and reduce operations of one allreduce step
// for this rank (ring, recursive doubling, binomial reduce then broadcast).
// ----------------------------------------------------------------------------
// Usage: program my_rank, group_size and algorithm_mode over the APB port
// while the block is idle (addresses 0, 4, 8; pready is always high).
// Each step_index transfer on the input channel (in_valid / in_stall) yields
// one to three operation transfers on the output channel
// (out_valid / out_stall), the final one marked by last_op. A bad
// configuration or a step past the end gives a single error operation.
// An accepted step is held in the input register; its operations are
// decoded in one pass and loaded into the operation buffer, from which
// the output port offers them in order. The single output port drains
// the buffer at one operation per cycle while out_stall is low. The next
// step is taken while the current one drains, so the output runs without
// gaps.
// Reset clears both stages and sets my_rank 0, group_size 1, mode ring.
// When the receiver stalls, the offered operation holds; the input register
// fills once and then in_stall rises until the buffer frees.
// ----------------------------------------------------------------------------
module allreduce_schedule_generator (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arsg_pkg::ADDR_W-1:0] paddr,
  input  logic [arsg_pkg::DATA_W-1:0] pwdata,
  output logic [arsg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // step input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [arsg_pkg::STEP_W-1:0] step_index,
  // operation output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [arsg_pkg::STEP_W-1:0] step_count,
  output logic [1:0]                  op_kind,
  output logic [arsg_pkg::RANK_W-1:0] peer_rank,
  output logic [1:0]                  first_buffer,
  output logic [arsg_pkg::SLOT_W-1:0] first_slot,
  output logic [1:0]                  second_buffer,
  output logic [arsg_pkg::SLOT_W-1:0] second_slot,
  output logic [1:0]                  dest_buffer,
  output logic [arsg_pkg::SLOT_W-1:0] dest_slot,
  output logic                        last_op
);
  import arsg_pkg::*;

  // configuration registers
  logic [RANK_W-1:0] my_rank;
  logic [SIZE_W-1:0] group_size;
  logic [MODE_W-1:0] alg_mode;
  logic              cfg_wr;

  // pipeline
  logic              s1_valid;
  logic [STEP_W-1:0] s1_step;
  logic              b_valid;
  logic [1:0]        b_count;
  logic [1:0]        b_idx;
  op_t               b_ops [NUM_OPS];
  op_t               cur;
  logic              in_xfer, out_xfer, b_done, b_load;

  // decode
  op_t               calc_ops [NUM_OPS];
  logic [1:0]        calc_count;
  op_t               base, err;
  logic [11:0]       n12, r12, s12;
  logic              cfg_bad, rd_ok, past_end;
  logic [STEP_W-1:0] tot;
  // ring
  logic [RANK_W-1:0] right, left;
  logic [11:0]       ring_total, t_ss1, t_rs1, ss1, rs1, k2, t_rs2, rs2, ss2p, ss2;
  // recursive doubling
  logic [3:0]        rd_total;
  logic [RANK_W-1:0] rd_peer;
  // binomial
  logic [RANK_W-1:0] lt, low, low_mask, hb, above_mask;
  logic [3:0]        rr, bs;
  logic [4:0]        bn_total;
  logic [SIZE_W-1:0] start;
  logic [STEP_W-1:0] q, bidx;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_rank    <= '0;
      group_size <= SIZE_W'(1);
      alg_mode   <= MODE_RING;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MY_RANK:    my_rank    <= pwdata[RANK_W-1:0];
        REG_GROUP_SIZE: group_size <= pwdata[SIZE_W-1:0];
        REG_ALG_MODE:   alg_mode   <= pwdata[MODE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MY_RANK:    prdata = DATA_W'(my_rank);
      REG_GROUP_SIZE: prdata = DATA_W'(group_size);
      REG_ALG_MODE:   prdata = DATA_W'(alg_mode);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign out_valid = b_valid;
  assign out_xfer  = b_valid && !out_stall;
  assign b_done    = out_xfer && (b_idx == b_count - 2'd1);
  assign b_load    = s1_valid && (!b_valid || b_done);
  assign in_stall  = s1_valid && !b_load;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (b_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_step <= step_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
      b_count <= '0;
    end else if (b_load) begin
      b_valid <= 1'b1;
      b_idx   <= '0;
      b_count <= calc_count;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end else if (out_xfer) begin
      b_idx <= b_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int k = 0; k < NUM_OPS; k++) begin
        b_ops[k] <= calc_ops[k];
      end
    end
  end

  always_comb begin
    case (b_idx)
      2'd0:    cur = b_ops[0];
      2'd1:    cur = b_ops[1];
      default: cur = b_ops[2];
    endcase
  end

  assign status        = cur.status;
  assign step_count    = cur.step_count;
  assign op_kind       = cur.op_kind;
  assign peer_rank     = cur.peer_rank;
  assign first_buffer  = cur.first_buffer;
  assign first_slot    = cur.first_slot;
  assign second_buffer = cur.second_buffer;
  assign second_slot   = cur.second_slot;
  assign dest_buffer   = cur.dest_buffer;
  assign dest_slot     = cur.dest_slot;
  assign last_op       = cur.last_op;

  // ---------------------------------------------------------------- decode
  assign n12 = {1'b0, group_size};
  assign r12 = {2'b00, my_rank};
  assign s12 = {1'b0, s1_step};

  // ring neighbors and chunk indexes, each a single wrap correction
  assign right      = (r12 + 12'd1 == n12) ? '0 : my_rank + RANK_W'(1);
  assign left       = (my_rank == '0) ? RANK_W'(group_size - SIZE_W'(1))
                                      : my_rank - RANK_W'(1);
  assign ring_total = (n12 - 12'd1) << 1;
  assign t_ss1      = r12 + n12 - s12;
  assign t_rs1      = t_ss1 - 12'd1;
  assign ss1        = (t_ss1 >= n12) ? t_ss1 - n12 : t_ss1;
  assign rs1        = (t_rs1 >= n12) ? t_rs1 - n12 : t_rs1;
  assign k2         = s12 - (n12 - 12'd1);
  assign t_rs2      = r12 + n12 - k2;
  assign rs2        = (t_rs2 >= n12) ? t_rs2 - n12 : t_rs2;
  assign ss2p       = rs2 + 12'd1;
  assign ss2        = (ss2p == n12) ? 12'd0 : ss2p;

  // recursive doubling
  assign rd_ok   = (group_size >= SIZE_W'(2)) &&
                   ((group_size & (group_size - SIZE_W'(1))) == '0);
  assign rd_peer = my_rank ^ (RANK_W'(1) << s1_step[3:0]);

  always_comb begin
    rd_total = '0;
    for (int j = 0; j < SIZE_W; j++) begin
      if (group_size[j]) rd_total = 4'(j);
    end
  end

  // binomial: lt marks the distances 2^j that still land inside the group
  always_comb begin
    for (int j = 0; j < RANK_W; j++) begin
      lt[j] = (r12 + (12'd1 << j)) < n12;
    end
  end

  always_comb begin
    hb = '0;
    for (int j = 0; j < RANK_W; j++) begin
      if (my_rank[j]) hb = RANK_W'(1) << j;
    end
  end

  assign low        = my_rank & (~my_rank + RANK_W'(1));
  assign low_mask   = low - RANK_W'(1);
  assign above_mask = (my_rank == '0) ? '1 : ~(hb | (hb - RANK_W'(1)));
  assign rr         = 4'($countones(lt & low_mask));
  assign bs         = 4'($countones(lt & above_mask));
  assign bn_total   = 5'(rr) + 5'(bs) + ((my_rank != '0) ? 5'd2 : 5'd0);
  assign start      = (my_rank == '0) ? SIZE_W'(1) : {hb, 1'b0};
  assign q          = s1_step - STEP_W'(rr);
  assign bidx       = (my_rank != '0) ? q - STEP_W'(2) : q;

  assign cfg_bad = (group_size == '0) || (group_size > MAX_SIZE) ||
                   ({1'b0, my_rank} >= group_size) ||
                   !(alg_mode == MODE_RING || alg_mode == MODE_RDBL ||
                     alg_mode == MODE_BINOM) ||
                   ((alg_mode == MODE_RDBL) && !rd_ok);

  always_comb begin
    if (cfg_bad) begin
      tot = '0;
    end else begin
      case (alg_mode)
        MODE_RING: tot = ring_total[STEP_W-1:0];
        MODE_RDBL: tot = STEP_W'(rd_total);
        default:   tot = STEP_W'(bn_total);
      endcase
    end
  end

  assign past_end = s1_step >= tot;

  always_comb begin
    base               = '0;
    base.status        = ST_OK;
    base.step_count    = tot;
    base.op_kind       = OP_SEND;
    base.first_buffer  = BUF_NONE;
    base.second_buffer = BUF_NONE;
    base.dest_buffer   = BUF_NONE;
    err                = base;
    err.last_op        = 1'b1;
    err.status         = cfg_bad ? ST_BAD_CFG : ST_PAST_END;
    calc_ops[0]        = err;
    calc_ops[1]        = base;
    calc_ops[2]        = base;
    calc_count         = 2'd1;

    if (!cfg_bad && !past_end) begin
      case (alg_mode)
        MODE_RING: begin
          if (s12 < n12 - 12'd1) begin
            // reduce-scatter
            calc_ops[0].op_kind      = OP_SEND;
            calc_ops[0].peer_rank    = right;
            calc_ops[0].first_buffer = (s1_step == '0) ? BUF_TX : BUF_RX;
            calc_ops[0].first_slot   = ss1[SLOT_W-1:0];
            calc_ops[0].last_op      = 1'b0;
            calc_ops[0].status       = ST_OK;
            calc_ops[1].op_kind      = OP_RECV;
            calc_ops[1].peer_rank    = left;
            calc_ops[1].first_buffer = BUF_TEMP;
            calc_ops[1].first_slot   = SLOT_WHOLE;
            calc_ops[2].op_kind       = OP_RED3;
            calc_ops[2].first_buffer  = BUF_TEMP;
            calc_ops[2].first_slot    = SLOT_WHOLE;
            calc_ops[2].second_buffer = BUF_TX;
            calc_ops[2].second_slot   = rs1[SLOT_W-1:0];
            calc_ops[2].dest_buffer   = BUF_RX;
            calc_ops[2].dest_slot     = rs1[SLOT_W-1:0];
            calc_ops[2].last_op       = 1'b1;
            calc_count                = 2'd3;
          end else begin
            // allgather
            calc_ops[0].op_kind      = OP_SEND;
            calc_ops[0].peer_rank    = right;
            calc_ops[0].first_buffer = BUF_RX;
            calc_ops[0].first_slot   = ss2[SLOT_W-1:0];
            calc_ops[0].last_op      = 1'b0;
            calc_ops[0].status       = ST_OK;
            calc_ops[1].op_kind      = OP_RECV;
            calc_ops[1].peer_rank    = left;
            calc_ops[1].first_buffer = BUF_RX;
            calc_ops[1].first_slot   = rs2[SLOT_W-1:0];
            calc_ops[1].last_op      = 1'b1;
            calc_count               = 2'd2;
          end
        end
        MODE_RDBL: begin
          calc_ops[0].op_kind      = OP_SEND;
          calc_ops[0].peer_rank    = rd_peer;
          calc_ops[0].first_buffer = (s1_step == '0) ? BUF_TX : BUF_RX;
          calc_ops[0].first_slot   = SLOT_WHOLE;
          calc_ops[0].last_op      = 1'b0;
          calc_ops[0].status       = ST_OK;
          calc_ops[1].op_kind      = OP_RECV;
          calc_ops[1].peer_rank    = rd_peer;
          calc_ops[1].first_buffer = BUF_TEMP;
          calc_ops[1].first_slot   = SLOT_WHOLE;
          calc_ops[2].first_buffer = BUF_TEMP;
          calc_ops[2].first_slot   = SLOT_WHOLE;
          calc_ops[2].dest_buffer  = BUF_RX;
          calc_ops[2].dest_slot    = SLOT_WHOLE;
          calc_ops[2].last_op      = 1'b1;
          if (s1_step == '0) begin
            calc_ops[2].op_kind       = OP_RED3;
            calc_ops[2].second_buffer = BUF_TX;
            calc_ops[2].second_slot   = SLOT_WHOLE;
          end else begin
            calc_ops[2].op_kind       = OP_RED2;
          end
          calc_count = 2'd3;
        end
        MODE_BINOM: begin
          calc_ops[0]              = base;
          calc_ops[0].first_slot   = SLOT_WHOLE;
          calc_ops[0].last_op      = 1'b1;
          if (s1_step < STEP_W'(rr)) begin
            // receive from a child and fold it in
            calc_ops[0].op_kind      = OP_RECV;
            calc_ops[0].peer_rank    = my_rank + (RANK_W'(1) << s1_step[3:0]);
            calc_ops[0].first_buffer = BUF_TEMP;
            calc_ops[0].last_op      = 1'b0;
            calc_ops[1].first_buffer = BUF_TEMP;
            calc_ops[1].first_slot   = SLOT_WHOLE;
            calc_ops[1].dest_buffer  = BUF_RX;
            calc_ops[1].dest_slot    = SLOT_WHOLE;
            calc_ops[1].last_op      = 1'b1;
            if (s1_step == '0) begin
              calc_ops[1].op_kind       = OP_RED3;
              calc_ops[1].second_buffer = BUF_TX;
              calc_ops[1].second_slot   = SLOT_WHOLE;
            end else begin
              calc_ops[1].op_kind       = OP_RED2;
            end
            calc_count = 2'd2;
          end else if (my_rank != '0 && q == '0) begin
            // partial result up to the parent
            calc_ops[0].op_kind      = OP_SEND;
            calc_ops[0].peer_rank    = my_rank - low;
            calc_ops[0].first_buffer = (rr == '0) ? BUF_TX : BUF_RX;
          end else if (my_rank != '0 && q == STEP_W'(1)) begin
            // broadcast arrives from the parent
            calc_ops[0].op_kind      = OP_RECV;
            calc_ops[0].peer_rank    = my_rank - hb;
            calc_ops[0].first_buffer = BUF_RX;
          end else begin
            calc_ops[0].op_kind      = OP_SEND;
            calc_ops[0].peer_rank    = my_rank + RANK_W'(start << bidx[3:0]);
            calc_ops[0].first_buffer = BUF_RX;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_count != 2'd0) && (b_idx < b_count))
    else $error("operation index beyond buffered count");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (cur.last_op == (b_idx == b_count - 2'd1)))
    else $error("last_op does not match final buffered operation");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (b_valid && cur.status != ST_OK) |-> (b_count == 2'd1))
    else $error("error result not alone in its step");

  a_no_gap_in_step: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !cur.last_op) |=> (b_valid && b_idx == $past(b_idx) + 2'd1))
    else $error("step operations not contiguous");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!b_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule
